### hdl/chtab_pkg.sv
// Shared types, constants and codes of the callsign hash table.
package chtab_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CALL_W = 58;
  localparam int HASH_W = 22;
  localparam int MODE_W = 2;
  localparam int KIND_W = 2;

  localparam int MUL_A_W  = 29;
  localparam int MUL_C_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_C_W;
  localparam int ACC_W    = 64;
  localparam int HASH_LSB = 42;
  localparam int STEP_W   = 3;

  localparam logic [MUL_C_W*2-1:0] HASH_MULT = 36'd47055833459;
  localparam logic [STEP_W-1:0]    MUL_LAST  = 3'd4;

  localparam int SHIFT_KEY12 = 10;
  localparam int SHIFT_KEY10 = 12;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAVE   = 2'd0,
    MODE_SEED   = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_22 = 2'd0,
    KIND_12 = 2'd1,
    KIND_10 = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_STORE,
    OP_LOOKUP
  } op_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_PUSH
  } fr_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    op_e                op;
    logic [CALL_W-1:0]  call;
    logic [HASH_W-1:0]  hash;
    logic [KIND_W-1:0]  kind;
  } cmd_t;

  typedef struct packed {
    logic               found;
    logic               present;
    logic               stored;
    logic [CALL_W-1:0]  call;
    logic [HASH_W-1:0]  hash;
  } res_t;

endpackage

### hdl/callsign_hash_table.sv
// Top level of the callsign hash table.
//
// Request words enter on in_valid_i/in_stall_o and carry a mode, a packed
// callsign, a hash key and a hash kind. Each request gives exactly one result
// word on out_valid_o/out_stall_i, in request order.
// A front end classifies each word and, for a seed request, computes the hash
// with a multiplier. Commands then wait in a two-entry queue for the table
// engine, which reads one table entry per cycle from a memory with one read
// and one write port and stops at the first match. The length of a scan grows
// with the number of entries filled so far, at most TABLE_ENTRIES; during a
// scan the front end and the queue keep taking words until the queue fills.
// Reset empties the table at once through a fill count; no clearing pass is
// needed. A stalled result holds in the output register while the front end
// and the queue keep taking words until the queue fills.
module callsign_hash_table #(
  parameter int TABLE_ENTRIES = chtab_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [chtab_pkg::MODE_W-1:0] mode_i,
  input  logic [chtab_pkg::CALL_W-1:0] call_packed_i,
  input  logic [chtab_pkg::HASH_W-1:0] hash_key_i,
  input  logic [chtab_pkg::KIND_W-1:0] hash_kind_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic                         already_present_o,
  output logic                         stored_o,
  output logic [chtab_pkg::CALL_W-1:0] call_out_o,
  output logic [chtab_pkg::HASH_W-1:0] hash_out_o
);
  import chtab_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  chtab_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .call_packed_i (call_packed_i),
    .hash_key_i    (hash_key_i),
    .hash_kind_i   (hash_kind_i),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .full_i        (full)
  );

  chtab_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  chtab_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .cmd_i             (pop_cmd),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .found_o           (found_o),
    .already_present_o (already_present_o),
    .stored_o          (stored_o),
    .call_out_o        (call_out_o),
    .hash_out_o        (hash_out_o)
  );

endmodule

### hdl/chtab_front.sv
// Front end: accepts request words, classifies them and computes seed hashes.
module chtab_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [chtab_pkg::MODE_W-1:0] mode_i,
  input  logic [chtab_pkg::CALL_W-1:0] call_packed_i,
  input  logic [chtab_pkg::HASH_W-1:0] hash_key_i,
  input  logic [chtab_pkg::KIND_W-1:0] hash_kind_i,
  output logic                         push_o,
  output chtab_pkg::cmd_t              cmd_o,
  input  logic                         full_i
);
  import chtab_pkg::*;

  fr_state_e           state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_C_W-1:0]  mul_c;
  logic [ACC_W-1:0]    addend;
  logic                accept;
  logic                call_zero;

  assign accept    = in_valid_i && (state_q == FR_IDLE);
  assign call_zero = (call_packed_i == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: begin
        if (in_valid_i) begin
          if ((mode_i == MODE_SEED) && !call_zero) begin
            state_d = FR_MUL;
          end else begin
            state_d = FR_PUSH;
          end
        end
      end
      FR_MUL: begin
        if (step_q == MUL_LAST) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != FR_IDLE);
    push_o     = (state_q == FR_PUSH) && !full_i;
  end

  always_comb begin
    case (step_q)
      3'd1: begin
        mul_a = cmd_q.call[MUL_A_W-1:0];
        mul_c = HASH_MULT[2*MUL_C_W-1:MUL_C_W];
      end
      3'd2: begin
        mul_a = cmd_q.call[CALL_W-1:MUL_A_W];
        mul_c = HASH_MULT[MUL_C_W-1:0];
      end
      3'd3: begin
        mul_a = cmd_q.call[CALL_W-1:MUL_A_W];
        mul_c = HASH_MULT[2*MUL_C_W-1:MUL_C_W];
      end
      default: begin
        mul_a = cmd_q.call[MUL_A_W-1:0];
        mul_c = HASH_MULT[MUL_C_W-1:0];
      end
    endcase
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_c);
    case (step_q)
      3'd1:    addend = ACC_W'(prod_q);
      3'd2:    addend = ACC_W'(prod_q) << MUL_C_W;
      3'd3:    addend = ACC_W'(prod_q) << MUL_A_W;
      3'd4:    addend = ACC_W'(prod_q) << (MUL_A_W + MUL_C_W);
      default: addend = '0;
    endcase
    acc_d  = (step_q == '0) ? '0 : acc_q + addend;
    step_d = (state_q == FR_MUL) ? step_q + STEP_W'(1) : '0;
  end

  always_comb begin
    cmd_d = cmd_q;
    if (accept) begin
      cmd_d.call = call_packed_i;
      cmd_d.hash = hash_key_i;
      cmd_d.kind = hash_kind_i;
      if (((mode_i == MODE_SAVE) || (mode_i == MODE_SEED)) && !call_zero) begin
        cmd_d.op = OP_STORE;
      end else if (mode_i == MODE_LOOKUP) begin
        cmd_d.op = OP_LOOKUP;
      end else begin
        cmd_d.op = OP_NOP;
      end
    end else if ((state_q == FR_MUL) && (step_q == MUL_LAST)) begin
      cmd_d.hash = acc_d[ACC_W-1:HASH_LSB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign cmd_o = cmd_q;

endmodule

### hdl/chtab_fifo.sv
// Short command queue between the front end and the table engine.
module chtab_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  chtab_pkg::cmd_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output chtab_pkg::cmd_t pop_data_o,
  output logic            empty_o
);
  import chtab_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/chtab_back.sv
// Table engine: scans the callsign table, inserts entries and drives results.
module chtab_back #(
  parameter int TABLE_ENTRIES = chtab_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  chtab_pkg::cmd_t              cmd_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic                         already_present_o,
  output logic                         stored_o,
  output logic [chtab_pkg::CALL_W-1:0] call_out_o,
  output logic [chtab_pkg::HASH_W-1:0] hash_out_o
);
  import chtab_pkg::*;

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  logic [CALL_W-1:0] call_mem [TABLE_ENTRIES];
  logic [HASH_W-1:0] hash_mem [TABLE_ENTRIES];

  bk_state_e         state_q, state_d;
  cmd_t              cmd_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   fill_q;
  logic [IdxW-1:0]   cursor_q;
  logic              pend_q, pend_d;
  logic [CALL_W-1:0] rd_call_q;
  logic [HASH_W-1:0] rd_hash_q;
  res_t              hold_q, hold_d;
  logic              hold_load;
  res_t              out_q;
  logic              out_valid_q;
  logic              out_free;
  logic              issue;
  logic              key_match;
  logic              hit;
  logic              scan_end;
  logic              mem_we;
  logic              load_out;
  logic [HASH_W-1:0] shifted;

  assign out_free = !out_valid_q || !out_stall_i;
  assign issue    = (state_q == BK_SCAN) && (cnt_q < fill_q);

  always_comb begin
    case (cmd_q.kind)
      KIND_12: shifted = rd_hash_q >> SHIFT_KEY12;
      KIND_10: shifted = rd_hash_q >> SHIFT_KEY10;
      default: shifted = rd_hash_q;
    endcase
    key_match = (shifted == cmd_q.hash);
    if (cmd_q.op == OP_STORE) begin
      hit = pend_q && (rd_call_q == cmd_q.call);
    end else begin
      hit = pend_q && key_match;
    end
    scan_end = (state_q == BK_SCAN) && (hit || (!issue && !pend_q));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = (cmd_i.op == OP_NOP) ? BK_EMIT : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = (state_q == BK_IDLE) && !empty_i;
    mem_we    = scan_end && !hit && (cmd_q.op == OP_STORE);
    load_out  = (state_q == BK_EMIT) && out_free;
    hold_load = scan_end || pop_o;
    hold_d    = '0;
    cnt_d     = pop_o ? '0 : cnt_q + CntW'(issue);
    pend_d    = issue && !hit;
    if (scan_end) begin
      if (cmd_q.op == OP_STORE) begin
        if (hit) begin
          hold_d.present = 1'b1;
          hold_d.hash    = rd_hash_q;
        end else begin
          hold_d.stored = 1'b1;
          hold_d.hash   = cmd_q.hash;
        end
      end else if (hit) begin
        hold_d.found = 1'b1;
        hold_d.call  = rd_call_q;
        hold_d.hash  = rd_hash_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      fill_q      <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      if (mem_we) begin
        if (cursor_q == IdxW'(TABLE_ENTRIES - 1)) begin
          cursor_q <= '0;
        end else begin
          cursor_q <= cursor_q + IdxW'(1);
        end
        if (fill_q != CntW'(TABLE_ENTRIES)) begin
          fill_q <= fill_q + CntW'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      call_mem[cursor_q] <= cmd_q.call;
      hash_mem[cursor_q] <= cmd_q.hash;
    end
    rd_call_q <= call_mem[cnt_q[IdxW-1:0]];
    rd_hash_q <= hash_mem[cnt_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (hold_load) begin
      hold_q <= hold_d;
    end
    if (load_out) begin
      out_q <= hold_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign found_o           = out_q.found;
  assign already_present_o = out_q.present;
  assign stored_o          = out_q.stored;
  assign call_out_o        = out_q.call;
  assign hash_out_o        = out_q.hash;

endmodule

### hdl/chtab_checker.sv
// Port-level assertion checker for the callsign hash table and its binding.
module chtab_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic                         found_o,
  input  logic                         already_present_o,
  input  logic                         stored_o,
  input  logic [chtab_pkg::CALL_W-1:0] call_out_o,
  input  logic [chtab_pkg::HASH_W-1:0] hash_out_o
);

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result word dropped while stalled.");

  a_hold_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(call_out_o) && $stable(hash_out_o))
    else $error("Result payload changed while stalled.");

  a_one_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({found_o, already_present_o, stored_o}))
    else $error("More than one outcome flag set.");

  a_call_only_on_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> call_out_o == '0)
    else $error("Callsign returned without a lookup match.");

  a_hash_zero_on_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o && !already_present_o && !stored_o |-> hash_out_o == '0)
    else $error("Hash returned for an empty result.");

endmodule

bind callsign_hash_table chtab_checker u_chtab_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .found_o           (found_o),
  .already_present_o (already_present_o),
  .stored_o          (stored_o),
  .call_out_o        (call_out_o),
  .hash_out_o        (hash_out_o)
);
